### sv/aabd_pkg.sv
// ----------------------------------------------------------------------------
// aabd_pkg
// Shared types and constants for the azimuth/altitude bilinear derate block.
// ----------------------------------------------------------------------------
package aabd_pkg;

    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLS    = 64;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int RCNT_W      = ROW_W + 1;
    localparam int CCNT_W      = COL_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int QUEUE_DEPTH = 2;

    // Arithmetic widths of the interpolation datapath.
    localparam int OPR_W  = 18;
    localparam int ACC_W  = 52;
    localparam int DEN_W  = 34;
    localparam int DVD_W  = 52;
    localparam int DCNT_W = $clog2(DVD_W);

    localparam logic [15:0]        FACTOR_ONE = 16'd32768;
    localparam logic signed [16:0] AZ_LIMIT   = 17'sd46080;
    localparam logic signed [15:0] ALT_LIMIT  = 16'sd11520;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS   = 2'd0,
        REG_COLS   = 2'd1,
        REG_ENABLE = 2'd2
    } aabd_reg_t;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_IMMED,
        KIND_LOOKUP
    } aabd_kind_t;

    typedef struct packed {
        aabd_kind_t         kind;
        logic [3:0]         row;
        logic [5:0]         col;
        logic [15:0]        value;
        logic signed [16:0] az;
        logic signed [15:0] alt;
        logic               oor;
    } aabd_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } aabd_qstat_t;

endpackage

### sv/aabd_front.sv
// ----------------------------------------------------------------------------
// aabd_front
// Accepts input transactions and sorts them into table loads, immediate
// answers and table lookups before they enter the queue.
// ----------------------------------------------------------------------------
module aabd_front import aabd_pkg::*; (
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [3:0]         row_index,
    input  logic [5:0]         col_index,
    input  logic [15:0]        entry_value,
    input  logic signed [16:0] azimuth,
    input  logic signed [15:0] altitude,
    input  logic               derate_enable,
    input  aabd_qstat_t        qstat,
    output logic               push,
    output aabd_item_t         item
);

    logic az_ok;
    logic alt_ok;

    assign az_ok  = !azimuth[16] && (azimuth <= AZ_LIMIT);
    assign alt_ok = !altitude[15] && (altitude <= ALT_LIMIT);

    assign in_stall = qstat.full;
    assign push     = in_valid && !qstat.full;

    always_comb
    begin
        item.row   = row_index;
        item.col   = col_index;
        item.value = entry_value;
        item.az    = azimuth;
        item.alt   = altitude;
        item.oor   = 1'b0;
        if (!action)
        begin
            item.kind = KIND_LOAD;
        end
        else if (!derate_enable)
        begin
            item.kind = KIND_IMMED;
        end
        else if (!(az_ok && alt_ok))
        begin
            item.kind = KIND_IMMED;
            item.oor  = 1'b1;
        end
        else
        begin
            item.kind = KIND_LOOKUP;
        end
    end

endmodule

### sv/aabd_queue.sv
// ----------------------------------------------------------------------------
// aabd_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module aabd_queue import aabd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  aabd_item_t  push_item,
    input  logic        pop,
    output aabd_item_t  head_item,
    output logic        head_valid,
    output aabd_qstat_t qstat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    aabd_item_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wp_reg;
    logic [PTR_W-1:0]   rp_reg;
    logic [PTR_W:0]     cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign qstat.full  = (cnt_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign head_valid  = !qstat.empty;
    assign head_item   = slot_reg[rp_reg];
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= (wp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_pop)
            begin
                rp_reg <= (rp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### sv/aabd_back.sv
// ----------------------------------------------------------------------------
// aabd_back
// Holds the table memory, performs loads, scans the headers, fetches the
// corner cells, forms the interpolation with a shared multiplier and a
// restoring divider, and drives the output register.
// ----------------------------------------------------------------------------
module aabd_back import aabd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  aabd_item_t        q_item,
    input  logic              q_valid,
    output logic              q_pop,
    input  logic [RCNT_W-1:0] rows_use,
    input  logic [CCNT_W-1:0] cols_use,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [15:0]       derate_factor,
    output logic              out_of_range
);

    typedef enum logic [3:0] {
        S_IDLE, S_ROWS, S_COLS, S_FETCH, S_DECIDE, S_MUL1, S_MUL2,
        S_ACC, S_DSET, S_DIV, S_FINAL, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        M_LERP_AZ, M_LERP_AL, M_BILIN
    } mode_t;

    localparam int FIN_W = DVD_W + 2;

    logic [15:0] mem [MAX_ROWS*MAX_COLS];

    state_t                    state_reg, state_next;
    mode_t                     mode_reg, mode_next;
    logic [CCNT_W-1:0]         iss_reg, iss_next;
    logic                      pv_reg, pv_next;
    logic [CCNT_W-1:0]         pidx_reg, pidx_next;
    logic                      poob_reg, poob_next;
    logic [15:0]               rd_data_reg;
    logic signed [16:0]        az_reg, az_next;
    logic signed [15:0]        alt_reg, alt_next;
    logic [ROW_W-1:0]          al_reg, al_next;
    logic [COL_W-1:0]          zl_reg, zl_next;
    logic signed [OPR_W-1:0]   ad_reg, ad_next;
    logic signed [OPR_W-1:0]   zd_reg, zd_next;
    logic [15:0]               v_reg [8];
    logic [15:0]               v_next [8];
    logic [2:0]                term_reg, term_next;
    logic [2:0]                last_reg, last_next;
    logic signed [2*OPR_W-1:0] p1_reg, p1_next;
    logic signed [3*OPR_W-1:0] p2_reg, p2_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [DEN_W-1:0]   den_reg, den_next;
    logic signed [OPR_W-1:0]   base_reg, base_next;
    logic                      use_div_reg, use_div_next;
    logic [DVD_W-1:0]          dq_reg, dq_next;
    logic [DEN_W-1:0]          rem_reg, rem_next;
    logic [DEN_W-1:0]          ud_reg, ud_next;
    logic                      neg_reg, neg_next;
    logic [DCNT_W-1:0]         dcnt_reg, dcnt_next;
    logic [15:0]               res_reg, res_next;
    logic                      res_oor_reg, res_oor_next;
    logic                      out_valid_reg, out_valid_next;
    logic [15:0]               out_factor_reg, out_factor_next;
    logic                      out_oor_reg, out_oor_next;

    logic [RCNT_W-1:0]         f_row;
    logic [CCNT_W-1:0]         f_col;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      f_oob;
    logic                      mem_we;
    logic signed [OPR_W-1:0]   val;
    logic signed [OPR_W-1:0]   alt_ext;
    logic signed [OPR_W-1:0]   az_ext;
    logic signed [OPR_W-1:0]   t0, t1, t2, t3, x0, x1, y0, y1;
    logic signed [OPR_W-1:0]   op_a, op_b, op_c;
    logic [CCNT_W-1:0]         r_last;
    logic [CCNT_W-1:0]         c_last;

    assign q_pop         = (state_reg == S_IDLE) && q_valid;
    assign mem_we        = q_pop && (q_item.kind == KIND_LOAD);
    assign out_valid     = out_valid_reg;
    assign derate_factor = out_factor_reg;
    assign out_of_range  = out_oor_reg;

    assign val     = poob_reg ? '0 : $signed({2'b00, rd_data_reg});
    assign alt_ext = OPR_W'(alt_reg);
    assign az_ext  = OPR_W'(az_reg);
    assign r_last  = CCNT_W'(rows_use) - CCNT_W'(1);
    assign c_last  = cols_use - CCNT_W'(1);

    assign t0 = $signed({2'b00, v_reg[0]});
    assign t1 = $signed({2'b00, v_reg[1]});
    assign t2 = $signed({2'b00, v_reg[2]});
    assign t3 = $signed({2'b00, v_reg[3]});
    assign x0 = $signed({2'b00, v_reg[4]});
    assign x1 = $signed({2'b00, v_reg[5]});
    assign y0 = $signed({2'b00, v_reg[6]});
    assign y1 = $signed({2'b00, v_reg[7]});

    // Read address: header scans, the four corner cells and their four header cells.
    always_comb
    begin
        f_row = '0;
        f_col = '0;
        case (state_reg)
            S_ROWS:
            begin
                f_row = iss_reg[RCNT_W-1:0];
            end
            S_COLS:
            begin
                f_col = iss_reg;
            end
            S_FETCH:
            begin
                case (iss_reg[2:0])
                    3'd0:
                    begin
                        f_row = {1'b0, al_reg};
                        f_col = {1'b0, zl_reg};
                    end
                    3'd1:
                    begin
                        f_row = {1'b0, al_reg};
                        f_col = {1'b0, zl_reg} + 1'b1;
                    end
                    3'd2:
                    begin
                        f_row = {1'b0, al_reg} + 1'b1;
                        f_col = {1'b0, zl_reg};
                    end
                    3'd3:
                    begin
                        f_row = {1'b0, al_reg} + 1'b1;
                        f_col = {1'b0, zl_reg} + 1'b1;
                    end
                    3'd4:
                    begin
                        f_row = {1'b0, al_reg};
                    end
                    3'd5:
                    begin
                        f_row = {1'b0, al_reg} + 1'b1;
                    end
                    3'd6:
                    begin
                        f_col = {1'b0, zl_reg};
                    end
                    default:
                    begin
                        f_col = {1'b0, zl_reg} + 1'b1;
                    end
                endcase
            end
            default:
            begin
                f_row = '0;
            end
        endcase
        rd_addr = {f_row[ROW_W-1:0], f_col[COL_W-1:0]};
        f_oob   = f_row[ROW_W] | f_col[COL_W];
    end

    // Multiplier operands for the current term.
    always_comb
    begin
        op_c = OPR_W'(1);
        case (mode_reg)
            M_LERP_AZ:
            begin
                op_a = t1 - t0;
                op_b = zd_reg;
            end
            M_LERP_AL:
            begin
                op_a = t2 - t0;
                op_b = ad_reg;
            end
            default:
            begin
                case (term_reg)
                    3'd0:
                    begin
                        op_a = x1 - alt_ext;
                        op_b = y1 - az_ext;
                        op_c = t0;
                    end
                    3'd1:
                    begin
                        op_a = alt_ext - x0;
                        op_b = y1 - az_ext;
                        op_c = t2;
                    end
                    3'd2:
                    begin
                        op_a = x1 - alt_ext;
                        op_b = az_ext - y0;
                        op_c = t1;
                    end
                    3'd3:
                    begin
                        op_a = alt_ext - x0;
                        op_b = az_ext - y0;
                        op_c = t3;
                    end
                    default:
                    begin
                        // Last pass forms the divisor dx * dy.
                        op_a = x1 - x0;
                        op_b = y1 - y0;
                    end
                endcase
            end
        endcase
    end

    always_comb
    begin
        logic                    issue;
        logic signed [OPR_W-1:0] span;
        logic signed [OPR_W-1:0] dx;
        logic signed [OPR_W-1:0] dy;
        logic                    direct;
        logic [ACC_W-1:0]        un;
        logic [DEN_W:0]          rem_s;
        logic                    ge;
        logic signed [FIN_W-1:0] q;
        logic signed [FIN_W-1:0] sum;

        state_next      = state_reg;
        mode_next       = mode_reg;
        iss_next        = iss_reg;
        pv_next         = 1'b0;
        pidx_next       = iss_reg;
        poob_next       = f_oob;
        az_next         = az_reg;
        alt_next        = alt_reg;
        al_next         = al_reg;
        zl_next         = zl_reg;
        ad_next         = ad_reg;
        zd_next         = zd_reg;
        v_next          = v_reg;
        term_next       = term_reg;
        last_next       = last_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        acc_next        = acc_reg;
        den_next        = den_reg;
        base_next       = base_reg;
        use_div_next    = use_div_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        ud_next         = ud_reg;
        neg_next        = neg_reg;
        dcnt_next       = dcnt_reg;
        res_next        = res_reg;
        res_oor_next    = res_oor_reg;
        out_factor_next = out_factor_reg;
        out_oor_next    = out_oor_reg;
        out_valid_next  = out_valid_reg && out_stall;
        issue           = 1'b0;
        span            = '0;
        dx              = '0;
        dy              = '0;
        direct          = 1'b0;
        un              = '0;
        rem_s           = '0;
        ge              = 1'b0;
        q               = '0;
        sum             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.kind)
                        KIND_IMMED:
                        begin
                            res_next     = FACTOR_ONE;
                            res_oor_next = q_item.oor;
                            state_next   = S_DONE;
                        end
                        KIND_LOOKUP:
                        begin
                            az_next    = q_item.az;
                            alt_next   = q_item.alt;
                            al_next    = ROW_W'(1);
                            zl_next    = COL_W'(1);
                            ad_next    = '0;
                            zd_next    = '0;
                            iss_next   = CCNT_W'(1);
                            state_next = S_ROWS;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ROWS:
            begin
                issue = (iss_reg < CCNT_W'(rows_use));
                if (pv_reg)
                begin
                    // Altitude headers decrease: keep the last row above the angle.
                    if (val > alt_ext)
                    begin
                        al_next = pidx_reg[ROW_W-1:0];
                        ad_next = (pidx_reg == r_last) ? '0 : val - alt_ext;
                    end
                    if (pidx_reg == r_last)
                    begin
                        iss_next   = CCNT_W'(1);
                        state_next = S_COLS;
                        issue      = 1'b0;
                    end
                end
            end
            S_COLS:
            begin
                issue = (iss_reg < cols_use);
                if (pv_reg)
                begin
                    if (az_ext > val)
                    begin
                        zl_next = pidx_reg[COL_W-1:0];
                        zd_next = (pidx_reg == c_last) ? '0 : az_ext - val;
                    end
                    if (pidx_reg == c_last)
                    begin
                        iss_next   = '0;
                        state_next = S_FETCH;
                        issue      = 1'b0;
                    end
                end
            end
            S_FETCH:
            begin
                issue = (iss_reg < CCNT_W'(8));
                if (pv_reg)
                begin
                    v_next[pidx_reg[2:0]] = val[15:0];
                    if (pidx_reg[2:0] == 3'd7)
                    begin
                        state_next = S_DECIDE;
                        issue      = 1'b0;
                    end
                end
            end
            S_DECIDE:
            begin
                dx        = x1 - x0;
                dy        = y1 - y0;
                mode_next = M_BILIN;
                last_next = 3'd4;
                if (ad_reg == '0 && zd_reg == '0)
                begin
                    direct = 1'b1;
                end
                else if (ad_reg == '0)
                begin
                    span      = dy;
                    direct    = (span == '0);
                    mode_next = M_LERP_AZ;
                end
                else if (zd_reg == '0)
                begin
                    span      = x0 - x1;
                    direct    = (span == '0);
                    mode_next = M_LERP_AL;
                end
                else if (dx == '0 && dy == '0)
                begin
                    direct = 1'b1;
                end
                else if (dx == '0)
                begin
                    span      = dy;
                    mode_next = M_LERP_AZ;
                end
                else if (dy == '0)
                begin
                    span      = x0 - x1;
                    mode_next = M_LERP_AL;
                end
                if (mode_next != M_BILIN)
                begin
                    last_next = 3'd0;
                end
                den_next  = DEN_W'(span);
                acc_next  = '0;
                term_next = '0;
                if (direct)
                begin
                    base_next    = t0;
                    use_div_next = 1'b0;
                    state_next   = S_FINAL;
                end
                else
                begin
                    base_next    = (mode_next == M_BILIN) ? '0 : t0;
                    use_div_next = 1'b1;
                    state_next   = S_MUL1;
                end
            end
            S_MUL1:
            begin
                p1_next    = op_a * op_b;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                p2_next    = p1_reg * op_c;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (mode_reg == M_BILIN && term_reg == 3'd4)
                begin
                    den_next = p2_reg[DEN_W-1:0];
                end
                else
                begin
                    acc_next = acc_reg + p2_reg[ACC_W-1:0];
                end
                if (term_reg == last_reg)
                begin
                    state_next = S_DSET;
                end
                else
                begin
                    term_next  = term_reg + 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_DSET:
            begin
                un         = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
                ud_next    = den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);
                dq_next    = DVD_W'(un) + DVD_W'(ud_next >> 1);
                neg_next   = acc_reg[ACC_W-1] ^ den_reg[DEN_W-1];
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_s     = {rem_reg, dq_reg[DVD_W-1]};
                ge        = (rem_s >= {1'b0, ud_reg});
                rem_next  = ge ? DEN_W'(rem_s - {1'b0, ud_reg}) : rem_s[DEN_W-1:0];
                dq_next   = {dq_reg[DVD_W-2:0], ge};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DVD_W - 1))
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                q = $signed({2'b00, dq_reg});
                if (neg_reg)
                begin
                    q = -q;
                end
                sum = FIN_W'(base_reg) + (use_div_reg ? q : '0);
                if (sum < 0)
                begin
                    res_next = '0;
                end
                else if (sum > FIN_W'(65535))
                begin
                    res_next = 16'hFFFF;
                end
                else
                begin
                    res_next = sum[15:0];
                end
                res_oor_next = 1'b0;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_factor_next = res_reg;
                    out_oor_next    = res_oor_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (issue)
        begin
            pv_next  = 1'b1;
            iss_next = iss_reg + 1'b1;
        end
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[{q_item.row, q_item.col}] <= q_item.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        iss_reg        <= iss_next;
        pidx_reg       <= pidx_next;
        poob_reg       <= poob_next;
        az_reg         <= az_next;
        alt_reg        <= alt_next;
        al_reg         <= al_next;
        zl_reg         <= zl_next;
        ad_reg         <= ad_next;
        zd_reg         <= zd_next;
        v_reg          <= v_next;
        term_reg       <= term_next;
        last_reg       <= last_next;
        p1_reg         <= p1_next;
        p2_reg         <= p2_next;
        acc_reg        <= acc_next;
        den_reg        <= den_next;
        base_reg       <= base_next;
        use_div_reg    <= use_div_next;
        dq_reg         <= dq_next;
        rem_reg        <= rem_next;
        ud_reg         <= ud_next;
        neg_reg        <= neg_next;
        dcnt_reg       <= dcnt_next;
        res_reg        <= res_next;
        res_oor_reg    <= res_oor_next;
        out_factor_reg <= out_factor_next;
        out_oor_reg    <= out_oor_next;
    end

endmodule

### sv/azimuth_altitude_bilinear_derate.sv
// ----------------------------------------------------------------------------
// azimuth_altitude_bilinear_derate
// Loads are written to the table as the back pops them. A lookup runs header
// scans at one memory read per cycle, up to five multiply passes and a
// restoring divider over a 52-bit dividend; a direct cell value skips both.
// Disabled or out-of-range queries skip the lookup. Reset clears
// control state and sets the registers to 16 rows, 64 columns, enabled;
// the table holds no defined contents until loaded.
// ----------------------------------------------------------------------------
module azimuth_altitude_bilinear_derate import aabd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [3:0]            row_index,
    input  logic [5:0]            col_index,
    input  logic [15:0]           entry_value,
    input  logic signed [16:0]    azimuth,
    input  logic signed [15:0]    altitude,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           derate_factor,
    output logic                  out_of_range,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [RCNT_W-1:0] rows_reg;
    logic [CCNT_W-1:0] cols_reg;
    logic              enable_reg;
    logic [RCNT_W-1:0] rows_use;
    logic [CCNT_W-1:0] cols_use;
    aabd_qstat_t       qstat;
    logic              push;
    aabd_item_t        push_item;
    aabd_item_t        head_item;
    logic              head_valid;
    logic              pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= RCNT_W'(MAX_ROWS);
            cols_reg   <= CCNT_W'(MAX_COLS);
            enable_reg <= 1'b1;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_ROWS:   rows_reg   <= cfg_data[RCNT_W-1:0];
                REG_COLS:   cols_reg   <= cfg_data[CCNT_W-1:0];
                REG_ENABLE: enable_reg <= cfg_data[0];
                default:    enable_reg <= enable_reg;
            endcase
        end
    end

    always_comb
    begin
        if (rows_reg < RCNT_W'(2))
        begin
            rows_use = RCNT_W'(2);
        end
        else if (rows_reg > RCNT_W'(MAX_ROWS))
        begin
            rows_use = RCNT_W'(MAX_ROWS);
        end
        else
        begin
            rows_use = rows_reg;
        end
        if (cols_reg < CCNT_W'(2))
        begin
            cols_use = CCNT_W'(2);
        end
        else if (cols_reg > CCNT_W'(MAX_COLS))
        begin
            cols_use = CCNT_W'(MAX_COLS);
        end
        else
        begin
            cols_use = cols_reg;
        end
    end

    aabd_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .row_index     (row_index),
        .col_index     (col_index),
        .entry_value   (entry_value),
        .azimuth       (azimuth),
        .altitude      (altitude),
        .derate_enable (enable_reg),
        .qstat         (qstat),
        .push          (push),
        .item          (push_item)
    );

    aabd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_item  (head_item),
        .head_valid (head_valid),
        .qstat      (qstat)
    );

    aabd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_item        (head_item),
        .q_valid       (head_valid),
        .q_pop         (pop),
        .rows_use      (rows_use),
        .cols_use      (cols_use),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .derate_factor (derate_factor),
        .out_of_range  (out_of_range)
    );

    // An out-of-range answer always carries factor one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (derate_factor == FACTOR_ONE))
        else $error("out_of_range result without factor one");

    // The back removes at most one transaction per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |=> !qstat.empty)
        else $error("queue drained by more than one entry in a cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty together");

endmodule
